@@ sv/mdsf_pkg.sv @@
// shared types and constants for the mouse delta smoothing filter
package mdsf_pkg;

   // event codes carried in the mode field
   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_MOVE    = 2'd1,
      MODE_PRESS   = 2'd2,
      MODE_RELEASE = 2'd3
   } mode_type;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_Q16     = 4'd1;
   localparam int unsigned CSR_DATA_W = 16;

   // field widths
   localparam int unsigned POS_W   = 24;
   localparam int unsigned DELTA_W = 16;
   localparam int unsigned OUT_W   = 24;
   localparam int unsigned FRAC_W  = 8;
   localparam int unsigned DECAY_W = 16;
   localparam int unsigned WGT_W   = 17;
   localparam int unsigned PROD_W  = 34;

   // divider sizing: quotient never exceeds 2^23
   localparam int unsigned QUOT_W    = 24;
   localparam int unsigned DIV_CNT_W = 5;

   // constants
   localparam logic [WGT_W-1:0]   WEIGHT_ONE  = 17'h10000;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'h8000;
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = -16'sh8000;
   localparam logic [OUT_W-1:0]   OUT_MAX     = 24'h7FFFFF;

   // history bank control
   typedef struct packed {
      logic push;
      logic rotate;
   } hist_ctl_type;

   // multiply-accumulate control
   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctl_type;

endpackage

@@ sv/mdsf_history.sv @@
// delta history shift register, rotated once per tap during a filter pass
module mdsf_history #(
   parameter int unsigned HISTORY_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mdsf_pkg::hist_ctl_type              ctl,
   input  logic signed [mdsf_pkg::DELTA_W-1:0] push_x,
   input  logic signed [mdsf_pkg::DELTA_W-1:0] push_y,
   output logic signed [mdsf_pkg::DELTA_W-1:0] tap_x,
   output logic signed [mdsf_pkg::DELTA_W-1:0] tap_y
);

   localparam int unsigned ENTRY_W = 2 * mdsf_pkg::DELTA_W;

   logic [ENTRY_W-1:0] hist_ff [HISTORY_DEPTH];

   // entry 0 holds the newest delta and is the tap read by the filter pass
   assign tap_x = $signed(hist_ff[0][ENTRY_W-1:mdsf_pkg::DELTA_W]);
   assign tap_y = $signed(hist_ff[0][mdsf_pkg::DELTA_W-1:0]);

   // push shifts toward older entries, rotate brings the next older entry to the tap
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_entry
      logic [ENTRY_W-1:0] push_in;
      logic [ENTRY_W-1:0] rot_in;

      if (i == 0) begin : g_head
         assign push_in = {push_x, push_y};
      end else begin : g_body
         assign push_in = hist_ff[i-1];
      end

      if (i == HISTORY_DEPTH - 1) begin : g_wrap
         assign rot_in = hist_ff[0];
      end else begin : g_next
         assign rot_in = hist_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hist_ff[i] <= '0;
         end else if (ctl.push) begin
            hist_ff[i] <= push_in;
         end else if (ctl.rotate) begin
            hist_ff[i] <= rot_in;
         end
      end
   end

endmodule

@@ sv/mdsf_mac.sv @@
// weight generator and multiply-accumulate unit, one history tap per cycle
module mdsf_mac #(
   parameter int unsigned HISTORY_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mdsf_pkg::mac_ctl_type               ctl,
   input  logic [mdsf_pkg::DECAY_W-1:0]        decay,
   input  logic signed [mdsf_pkg::DELTA_W-1:0] tap_x,
   input  logic signed [mdsf_pkg::DELTA_W-1:0] tap_y,
   output logic signed [mdsf_pkg::PROD_W+$clog2(HISTORY_DEPTH)-1:0] acc_x,
   output logic signed [mdsf_pkg::PROD_W+$clog2(HISTORY_DEPTH)-1:0] acc_y,
   output logic [mdsf_pkg::WGT_W+$clog2(HISTORY_DEPTH)-1:0]        wsum
);

   localparam int unsigned LOG_D = $clog2(HISTORY_DEPTH);
   localparam int unsigned PROD_W = mdsf_pkg::PROD_W;
   localparam int unsigned ACC_W = mdsf_pkg::PROD_W + LOG_D;
   localparam int unsigned WS_W  = mdsf_pkg::WGT_W + LOG_D;
   localparam int unsigned WPROD_W = mdsf_pkg::WGT_W + mdsf_pkg::DECAY_W;

   logic [mdsf_pkg::WGT_W-1:0]               w_ff;
   logic [mdsf_pkg::WGT_W-1:0]               wtap_ff;
   logic signed [mdsf_pkg::PROD_W-1:0]       prod_x_ff;
   logic signed [mdsf_pkg::PROD_W-1:0]       prod_y_ff;
   logic                                     prod_valid_ff;
   logic signed [ACC_W-1:0]                  acc_x_ff;
   logic signed [ACC_W-1:0]                  acc_y_ff;
   logic [WS_W-1:0]                          wsum_ff;
   logic [WPROD_W-1:0]                       wprod;

   // next weight is floor(w * decay / 65536)
   assign wprod = WPROD_W'(w_ff) * WPROD_W'(decay);

   // product stage
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         w_ff <= mdsf_pkg::WEIGHT_ONE;
      end else if (ctl.step) begin
         w_ff      <= wprod[WPROD_W-1:mdsf_pkg::DECAY_W];
         wtap_ff   <= w_ff;
         prod_x_ff <= PROD_W'($signed({1'b0, w_ff})) * PROD_W'(tap_x);
         prod_y_ff <= PROD_W'($signed({1'b0, w_ff})) * PROD_W'(tap_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.step;
      end
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         wsum_ff  <= '0;
      end else if (prod_valid_ff) begin
         acc_x_ff <= acc_x_ff + ACC_W'(prod_x_ff);
         acc_y_ff <= acc_y_ff + ACC_W'(prod_y_ff);
         wsum_ff  <= wsum_ff + WS_W'(wtap_ff);
      end
   end

   assign acc_x = acc_x_ff;
   assign acc_y = acc_y_ff;
   assign wsum  = wsum_ff;

endmodule

@@ sv/mdsf_div.sv @@
// restoring divider, one quotient bit per cycle, shared by both axes
module mdsf_div #(
   parameter int unsigned DVD_W = 45,
   parameter int unsigned DIV_W = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DVD_W-1:0]                  dividend,
   input  logic [DIV_W-1:0]                  divisor,
   output logic                              done,
   output logic [mdsf_pkg::QUOT_W-1:0]       quotient
);

   localparam int unsigned QW = mdsf_pkg::QUOT_W;
   localparam int unsigned CW = mdsf_pkg::DIV_CNT_W;

   logic [DIV_W-1:0]                  rem_ff;
   logic [DIV_W-1:0]                  divisor_ff;
   logic [QW-1:0]                     shreg_ff;
   logic [mdsf_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;
   logic [DIV_W:0]                    rem2;
   logic [DIV_W:0]                    diff;
   logic                              ge;

   // trial subtract of the divisor from the shifted remainder
   assign rem2 = {rem_ff, shreg_ff[QW-1]};
   assign diff = rem2 - {1'b0, divisor_ff};
   assign ge   = (rem2 >= {1'b0, divisor_ff});

   // datapath: upper dividend bits start as remainder, since the quotient fits QW bits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= dividend[QW +: DIV_W];
         shreg_ff   <= dividend[QW-1:0];
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
         shreg_ff <= {shreg_ff[QW-2:0], ge};
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = shreg_ff;

endmodule

@@ sv/mouse_delta_smoothing_filter_unit.sv @@
// top level of the mouse delta smoothing filter: event decode, sequencer, result register
//
//  channel | direction | handshake          | beat
//  req_    | in        | req_valid/req_stall | mode, right_button, pos_x, pos_y
//  rsp_    | out       | rsp_valid/rsp_stall | delta_x, delta_y
//  csr_    | in        | csr_valid/csr_ready | index, data (always ready)
//
// ticks, button events and moves without a result are handled in the idle state; a raw
// move while dragging passes through the done state to the rsp register.
// a filtered move while dragging makes one multiply pass per history tap, then runs
// the 24-step divider once per axis.
// reset is synchronous; it clears the history, position, flags and registers.
// a new req beat is taken while a result waits in the rsp register; a second
// finished result holds req_stall high until that register frees up.
module mouse_delta_smoothing_filter_unit #(
   parameter int unsigned HISTORY_DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_mode,
   input  logic                                   req_right_button,
   input  logic signed [mdsf_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [mdsf_pkg::POS_W-1:0]      req_pos_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mdsf_pkg::OUT_W-1:0]      rsp_delta_x,
   output logic signed [mdsf_pkg::OUT_W-1:0]      rsp_delta_y,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mdsf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mdsf_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int unsigned LOG_D = $clog2(HISTORY_DEPTH);
   localparam int unsigned CNT_W = (LOG_D > 0) ? LOG_D : 1;
   localparam int unsigned ACC_W = mdsf_pkg::PROD_W + LOG_D;
   localparam int unsigned WS_W  = mdsf_pkg::WGT_W + LOG_D;
   localparam int unsigned DVD_W = ACC_W + mdsf_pkg::FRAC_W + 1;
   localparam int unsigned PW    = mdsf_pkg::POS_W;
   localparam int unsigned DW    = mdsf_pkg::DELTA_W;
   localparam int unsigned OW    = mdsf_pkg::OUT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_DIVX_GO,
      S_DIVX_RUN,
      S_DIVY_GO,
      S_DIVY_RUN,
      S_DONE
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          tap_cnt_ff;
   logic                      filter_enable_ff;
   logic [mdsf_pkg::DECAY_W-1:0] decay_ff;
   logic signed [PW-1:0]      last_x_ff;
   logic signed [PW-1:0]      last_y_ff;
   logic                      dragging_ff;
   logic                      refresh_ff;
   logic                      neg_ff;
   logic signed [OW-1:0]      pend_x_ff;
   logic signed [OW-1:0]      pend_y_ff;
   logic                      rsp_valid_ff;
   logic signed [OW-1:0]      rsp_x_ff;
   logic signed [OW-1:0]      rsp_y_ff;

   logic                      req_accept;
   logic                      slot_free;
   logic signed [PW:0]        diff_x;
   logic signed [PW:0]        diff_y;
   logic signed [DW-1:0]      dx;
   logic signed [DW-1:0]      dy;
   logic signed [DW-1:0]      hist_push_x;
   logic signed [DW-1:0]      hist_push_y;
   logic signed [DW-1:0]      tap_x;
   logic signed [DW-1:0]      tap_y;
   mdsf_pkg::hist_ctl_type    hist_ctl;
   mdsf_pkg::mac_ctl_type     mac_ctl;
   logic signed [ACC_W-1:0]   acc_x;
   logic signed [ACC_W-1:0]   acc_y;
   logic signed [ACC_W-1:0]   acc_sel;
   logic [WS_W-1:0]           wsum;
   logic [ACC_W-1:0]          acc_mag;
   logic [DVD_W-1:0]          dividend;
   logic                      div_start;
   logic                      div_done;
   logic [mdsf_pkg::QUOT_W-1:0] quotient;
   logic signed [OW-1:0]      fin;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // position deltas, saturated to 16 bits
   assign diff_x = {req_pos_x[PW-1], req_pos_x} - {last_x_ff[PW-1], last_x_ff};
   assign diff_y = {req_pos_y[PW-1], req_pos_y} - {last_y_ff[PW-1], last_y_ff};

   always_comb begin
      if (diff_x > (PW+1)'(mdsf_pkg::DELTA_MAX)) begin
         dx = mdsf_pkg::DELTA_MAX;
      end else if (diff_x < (PW+1)'(mdsf_pkg::DELTA_MIN)) begin
         dx = mdsf_pkg::DELTA_MIN;
      end else begin
         dx = diff_x[DW-1:0];
      end
      if (diff_y > (PW+1)'(mdsf_pkg::DELTA_MAX)) begin
         dy = mdsf_pkg::DELTA_MAX;
      end else if (diff_y < (PW+1)'(mdsf_pkg::DELTA_MIN)) begin
         dy = mdsf_pkg::DELTA_MIN;
      end else begin
         dy = diff_y[DW-1:0];
      end
   end

   // history control: moves push their delta, ticks push zero when refresh is armed
   always_comb begin
      hist_ctl.push   = 1'b0;
      hist_ctl.rotate = (state_ff == S_MAC);
      hist_push_x     = dx;
      hist_push_y     = dy;
      if (req_accept) begin
         if (req_mode == mdsf_pkg::MODE_MOVE) begin
            hist_ctl.push = 1'b1;
         end else if (req_mode == mdsf_pkg::MODE_TICK && refresh_ff) begin
            hist_ctl.push = 1'b1;
            hist_push_x   = '0;
            hist_push_y   = '0;
         end
      end
   end

   assign mac_ctl.clear = req_accept && (req_mode == mdsf_pkg::MODE_MOVE);
   assign mac_ctl.step  = (state_ff == S_MAC);

   mdsf_history #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock  (clock),
      .reset  (reset),
      .ctl    (hist_ctl),
      .push_x (hist_push_x),
      .push_y (hist_push_y),
      .tap_x  (tap_x),
      .tap_y  (tap_y)
   );

   mdsf_mac #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .decay (decay_ff),
      .tap_x (tap_x),
      .tap_y (tap_y),
      .acc_x (acc_x),
      .acc_y (acc_y),
      .wsum  (wsum)
   );

   // dividend: |acc| * 256 plus half the weight sum for round half away from zero
   assign acc_sel   = (state_ff == S_DIVY_GO) ? acc_y : acc_x;
   assign acc_mag   = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
   assign dividend  = {1'b0, acc_mag, {mdsf_pkg::FRAC_W{1'b0}}} + DVD_W'(wsum >> 1);
   assign div_start = (state_ff == S_DIVX_GO) || (state_ff == S_DIVY_GO);

   mdsf_div #(
      .DVD_W(DVD_W),
      .DIV_W(WS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (wsum),
      .done     (div_done),
      .quotient (quotient)
   );

   // restore sign; only a positive 2^23 can overflow
   always_comb begin
      if (neg_ff) begin
         fin = -$signed(quotient);
      end else if (quotient[OW-1]) begin
         fin = $signed(mdsf_pkg::OUT_MAX);
      end else begin
         fin = $signed(quotient);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b1;
         decay_ff         <= mdsf_pkg::DECAY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mdsf_pkg::CSR_FILTER_ENABLE: filter_enable_ff <= csr_data[0];
            mdsf_pkg::CSR_DECAY_Q16:     decay_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   // event decode: position, dragging and refresh state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         dragging_ff <= 1'b0;
         refresh_ff  <= 1'b1;
      end else if (req_accept) begin
         unique case (req_mode) inside
            mdsf_pkg::MODE_TICK: begin
               refresh_ff <= 1'b1;
            end
            mdsf_pkg::MODE_MOVE: begin
               refresh_ff <= 1'b0;
               last_x_ff  <= req_pos_x;
               last_y_ff  <= req_pos_y;
            end
            mdsf_pkg::MODE_PRESS, mdsf_pkg::MODE_RELEASE: begin
               if (req_right_button) begin
                  dragging_ff <= (req_mode == mdsf_pkg::MODE_PRESS);
                  last_x_ff   <= req_pos_x;
                  last_y_ff   <= req_pos_y;
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept && req_mode == mdsf_pkg::MODE_MOVE && dragging_ff) begin
                  if (filter_enable_ff) begin
                     tap_cnt_ff <= '0;
                     state_ff   <= S_MAC;
                  end else begin
                     pend_x_ff <= {dx, {mdsf_pkg::FRAC_W{1'b0}}};
                     pend_y_ff <= {dy, {mdsf_pkg::FRAC_W{1'b0}}};
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_MAC: begin
               tap_cnt_ff <= tap_cnt_ff + CNT_W'(1);
               if (tap_cnt_ff == CNT_W'(HISTORY_DEPTH - 1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_DIVX_GO;
            end
            S_DIVX_GO: begin
               neg_ff   <= acc_sel[ACC_W-1];
               state_ff <= S_DIVX_RUN;
            end
            S_DIVX_RUN: begin
               if (div_done) begin
                  pend_x_ff <= fin;
                  state_ff  <= S_DIVY_GO;
               end
            end
            S_DIVY_GO: begin
               neg_ff   <= acc_sel[ACC_W-1];
               state_ff <= S_DIVY_RUN;
            end
            S_DIVY_RUN: begin
               if (div_done) begin
                  pend_y_ff <= fin;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_x_ff     <= pend_x_ff;
                  rsp_y_ff     <= pend_y_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_delta_x = rsp_x_ff;
   assign rsp_delta_y = rsp_y_ff;

endmodule
